[rtl/core/tce_pkg.sv]
// ----------------------------------------------------------------------------
// Tile coverage enumerator package
// Shared widths, register indexes and the word types of both channels.
// ----------------------------------------------------------------------------
package tce_pkg;

  localparam int unsigned CoordW  = 16;
  localparam int unsigned ViewW   = 15;
  localparam int unsigned GridW   = 13;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 16;

  localparam logic [CfgIdxW-1:0] RegCanvasWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegCanvasHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] RegGridWidth    = 2'd2;
  localparam logic [CfgIdxW-1:0] RegGridHeight   = 2'd3;

  typedef struct packed {
    logic signed [CoordW-1:0] view_left;
    logic signed [CoordW-1:0] view_top;
    logic [ViewW-1:0]         view_width;
    logic [ViewW-1:0]         view_height;
  } view_t;

  typedef struct packed {
    logic [CoordW-1:0] tile_left;
    logic [CoordW-1:0] tile_top;
    logic [GridW-1:0]  tile_width;
    logic [GridW-1:0]  tile_height;
    logic              last_tile;
    logic              no_tiles;
    logic              truncated;
  } tile_t;

  typedef struct packed {
    logic              start;
    logic [CoordW-1:0] dividend;
    logic [GridW-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [CoordW-1:0] quotient;
    logic [GridW-1:0]  remainder;
  } div_rsp_t;

endpackage

[rtl/core/tce_view_if.sv]
// ----------------------------------------------------------------------------
// Viewport channel
// Valid/ready channel that carries one viewport word.
// ----------------------------------------------------------------------------
interface tce_view_if import tce_pkg::*; ();
  logic  valid;
  logic  ready;
  view_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/core/tce_tile_if.sv]
// ----------------------------------------------------------------------------
// Tile channel
// Valid/ready channel that carries one tile result word.
// ----------------------------------------------------------------------------
interface tce_tile_if import tce_pkg::*; ();
  logic  valid;
  logic  ready;
  tile_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/core/tce_divider.sv]
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tce_divider import tce_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(CoordW + 1);

  logic [CoordW-1:0] dvd_q, dvd_d;
  logic [GridW-1:0]  rem_q, rem_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [GridW:0]    trial;
  logic              fits;

  assign trial = {rem_q, dvd_q[CoordW-1]};
  assign fits  = trial >= {1'b0, req_i.divisor};

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      dvd_d  = req_i.dividend;
      rem_d  = '0;
      cnt_d  = CntW'(CoordW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // The remainder stays below the divisor, so the difference fits GridW bits.
      rem_d = fits ? GridW'(trial - {1'b0, req_i.divisor}) : trial[GridW-1:0];
      dvd_d = {dvd_q[CoordW-2:0], fits};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = dvd_q;
  assign rsp_o.remainder = rem_q;

endmodule

[rtl/core/tile_coverage_enumerator.sv]
// ----------------------------------------------------------------------------
// Tile coverage enumerator
// Clips a viewport to the canvas and lists the covered tiles row by row.
// ----------------------------------------------------------------------------
// An empty clip gives its single word in the cycle after acceptance.
// Otherwise four divisions run in turn on the one shared divider, then one
// setup step, then one tile word per cycle while the output is not stalled
// (up to MAX_SIDE * MAX_SIDE words). No viewport is taken until the last
// word has left. Reset is asynchronous and active low; it returns the
// registers to 512 and the sequencer to idle.
module tile_coverage_enumerator import tce_pkg::*; #(
  parameter int unsigned MAX_SIDE   = 8,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  tce_view_if.sink           view_i,
  tce_tile_if.source         tile_o
);

  localparam int unsigned SideW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam logic [CoordW-1:0] CoordMask =
    (COORD_BITS >= CoordW) ? {CoordW{1'b1}} : CoordW'((64'd1 << COORD_BITS) - 64'd1);
  localparam logic [CoordW-1:0] SideLim = CoordW'(MAX_SIDE);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DIV   = 5'b00010,
    S_SETUP = 5'b00100,
    S_EMIT  = 5'b01000,
    S_DRAIN = 5'b10000
  } tce_state_e;

  typedef struct packed {
    logic              empty;
    logic [CoordW-1:0] lo;
    logic [CoordW-1:0] hi_m1;
  } clip_t;

  // Clips [pos, pos + len) to [0, size).
  function automatic clip_t clip_axis(logic [CoordW-1:0] pos, logic [ViewW-1:0] len,
                                      logic [CoordW-1:0] size);
    logic signed [CoordW+1:0] b;
    logic signed [CoordW+1:0] s;
    logic signed [CoordW+1:0] bm;
    logic [CoordW-1:0]        a;
    clip_t                    r;
    b  = $signed({{2{pos[CoordW-1]}}, pos}) + $signed({3'b000, len});
    s  = $signed({2'b00, size});
    bm = (b < s) ? b : s;
    a  = pos[CoordW-1] ? '0 : pos;
    r.empty = bm <= $signed({2'b00, a});
    r.lo    = a;
    r.hi_m1 = CoordW'(bm - 1);
    return r;
  endfunction

  // Configuration registers.
  logic [CoordW-1:0] cw_q, ch_q;
  logic [GridW-1:0]  gw_q, gh_q;
  logic [GridW-1:0]  gw, gh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cw_q <= CoordW'(512);
      ch_q <= CoordW'(512);
      gw_q <= GridW'(512);
      gh_q <= GridW'(512);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegCanvasWidth:  cw_q <= cfg_data_i;
        RegCanvasHeight: ch_q <= cfg_data_i;
        RegGridWidth:    gw_q <= cfg_data_i[GridW-1:0];
        RegGridHeight:   gh_q <= cfg_data_i[GridW-1:0];
        default: ;
      endcase
    end
  end

  // A tile size of zero behaves as one.
  assign gw = (gw_q == '0) ? GridW'(1) : gw_q;
  assign gh = (gh_q == '0) ? GridW'(1) : gh_q;

  clip_t clip_x, clip_y;
  assign clip_x = clip_axis(view_i.data.view_left, view_i.data.view_width, cw_q);
  assign clip_y = clip_axis(view_i.data.view_top, view_i.data.view_height, ch_q);

  // Sequencer state.
  tce_state_e        state_q, state_d;
  logic [1:0]        div_idx_q, div_idx_d;
  logic              div_go_q, div_go_d;
  logic [CoordW-1:0] x0_q, x1m1_q, y0_q, y1m1_q;
  logic [CoordW-1:0] c0_q, c1_q, r0_q, r1_q;
  logic [CoordW-1:0] tx0_q, ty0_q, tx_q, ty_q;
  logic [SideW-1:0]  col_q, row_q, last_col_q, last_row_q;
  logic              trunc_q;
  logic              out_valid_q, out_valid_d;
  tile_t             out_q, out_d;

  div_req_t div_req;
  div_rsp_t div_rsp;

  tce_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Divisions 0 and 1 run on the x corners, 2 and 3 on the y corners.
  always_comb begin
    div_req.start   = div_go_q;
    div_req.divisor = div_idx_q[1] ? gh : gw;
    case (div_idx_q)
      2'd0:    div_req.dividend = x0_q;
      2'd1:    div_req.dividend = x1m1_q;
      2'd2:    div_req.dividend = y0_q;
      default: div_req.dividend = y1m1_q;
    endcase
  end

  logic              accept;
  logic              load;
  logic [CoordW-1:0] dc, dr;
  logic              trunc_c, trunc_r;
  logic [CoordW-1:0] w_room, h_room;
  logic [GridW-1:0]  tw, th;
  logic              at_last_col, at_last;

  assign view_i.ready = (state_q == S_IDLE);
  assign accept       = view_i.valid && view_i.ready;
  assign load         = (state_q == S_EMIT) && (!out_valid_q || tile_o.ready);

  assign dc      = c1_q - c0_q;
  assign dr      = r1_q - r0_q;
  assign trunc_c = dc >= SideLim;
  assign trunc_r = dr >= SideLim;

  // Tiles start inside the canvas, so the room left is always positive.
  assign w_room = cw_q - tx_q;
  assign h_room = ch_q - ty_q;
  assign tw     = (w_room > {3'b000, gw}) ? gw : w_room[GridW-1:0];
  assign th     = (h_room > {3'b000, gh}) ? gh : h_room[GridW-1:0];

  assign at_last_col = col_q == last_col_q;
  assign at_last     = at_last_col && (row_q == last_row_q);

  always_comb begin
    state_d     = state_q;
    div_idx_d   = div_idx_q;
    div_go_d    = 1'b0;
    out_valid_d = out_valid_q && !tile_o.ready;
    out_d       = out_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (clip_x.empty || clip_y.empty) begin
            out_d       = '0;
            out_d.last_tile = 1'b1;
            out_d.no_tiles  = 1'b1;
            out_valid_d = 1'b1;
            state_d     = S_DRAIN;
          end else begin
            div_idx_d = 2'd0;
            div_go_d  = 1'b1;
            state_d   = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          if (div_idx_q == 2'd3) begin
            state_d = S_SETUP;
          end else begin
            div_idx_d = div_idx_q + 2'd1;
            div_go_d  = 1'b1;
          end
        end
      end
      S_SETUP: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (load) begin
          out_d.tile_left   = tx_q & CoordMask;
          out_d.tile_top    = ty_q & CoordMask;
          out_d.tile_width  = tw;
          out_d.tile_height = th;
          out_d.last_tile   = at_last;
          out_d.no_tiles    = 1'b0;
          out_d.truncated   = at_last && trunc_q;
          out_valid_d       = 1'b1;
          if (at_last) begin
            state_d = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        if (tile_o.ready) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      div_idx_q   <= 2'd0;
      div_go_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      div_idx_q   <= div_idx_d;
      div_go_q    <= div_go_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (accept) begin
      x0_q   <= clip_x.lo;
      x1m1_q <= clip_x.hi_m1;
      y0_q   <= clip_y.lo;
      y1m1_q <= clip_y.hi_m1;
    end
    if ((state_q == S_DIV) && div_rsp.done) begin
      // The first covered tile starts at the corner minus its remainder.
      case (div_idx_q)
        2'd0: begin
          c0_q  <= div_rsp.quotient;
          tx0_q <= x0_q - {3'b000, div_rsp.remainder};
        end
        2'd1: c1_q <= div_rsp.quotient;
        2'd2: begin
          r0_q  <= div_rsp.quotient;
          ty0_q <= y0_q - {3'b000, div_rsp.remainder};
        end
        default: r1_q <= div_rsp.quotient;
      endcase
    end
    if (state_q == S_SETUP) begin
      last_col_q <= trunc_c ? SideW'(MAX_SIDE - 1) : dc[SideW-1:0];
      last_row_q <= trunc_r ? SideW'(MAX_SIDE - 1) : dr[SideW-1:0];
      trunc_q    <= trunc_c || trunc_r;
      col_q      <= '0;
      row_q      <= '0;
      tx_q       <= tx0_q;
      ty_q       <= ty0_q;
    end else if (load) begin
      if (at_last_col) begin
        col_q <= '0;
        row_q <= row_q + SideW'(1);
        tx_q  <= tx0_q;
        ty_q  <= CoordW'(ty_q + {3'b000, gh});
      end else begin
        col_q <= col_q + SideW'(1);
        tx_q  <= CoordW'(tx_q + {3'b000, gw});
      end
    end
  end

  assign tile_o.valid = out_valid_q;
  assign tile_o.data  = out_q;

endmodule
